// ----- sv/utl_pkg.sv -----
// Package for the UTF-8 text cursor layout unit.
// Holds widths, register indexes, byte codes, the event and config types and
// the coordinate saturation function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package utl_pkg;

  localparam int COORD_BITS = 17;
  localparam int CALC_W     = ((COORD_BITS > 16) ? COORD_BITS : 16) + 3;
  localparam int CP_W       = 21;
  localparam int PEN_W      = 17;
  localparam int ACC_W      = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FONT_SIZE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_ENABLE = 3'd7;

  localparam logic [7:0] LEAD2_MASK = 8'he0;
  localparam logic [7:0] LEAD2_CODE = 8'hc0;
  localparam logic [7:0] LEAD3_MASK = 8'hf0;
  localparam logic [7:0] LEAD3_CODE = 8'he0;
  localparam logic [7:0] LEAD4_MASK = 8'hf8;
  localparam logic [7:0] LEAD4_CODE = 8'hf0;

  localparam logic [CP_W-1:0] NEWLINE_CP = 21'd10;
  localparam logic [CP_W-1:0] INVALID_CP = 21'd63;

  typedef logic signed [CALC_W-1:0]     calc_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;

  localparam calc_t COORD_MAX = calc_t'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam calc_t COORD_MIN = calc_t'(-(64'sd1 <<< (COORD_BITS - 1)));

  typedef struct packed {
    logic            start;
    logic            stop;
    logic            cp_valid;
    logic [CP_W-1:0] cp;
  } utl_event_t;

  typedef struct packed {
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [14:0] box_width;
    logic [14:0] box_height;
    logic [14:0] image_width;
    logic [11:0] font_size;
    logic [12:0] line_pitch;
    logic        wrap_enable;
  } utl_cfg_t;

  function automatic coord_t sat_coord(calc_t v);
    coord_t r;
    if (v > COORD_MAX) begin
      r = COORD_MAX[COORD_BITS-1:0];
    end else if (v < COORD_MIN) begin
      r = COORD_MIN[COORD_BITS-1:0];
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/utl_decode.sv -----
// Front end: UTF-8 byte decoder of the text cursor layout unit.
// Turns accepted bytes into layout events. Depends on utl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utl_decode
  import utl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] text_byte,
  input  wire logic       string_start,
  output utl_event_t      push_event,
  output logic            push
);

  logic [1:0]       pend_r, pend_nxt, pend0;
  logic [ACC_W-1:0] acc_r, acc_nxt, acc0;
  logic [CP_W-1:0]  cont_cp;
  utl_event_t       ev;

  always_comb begin
    pend0    = string_start ? 2'd0 : pend_r;
    acc0     = string_start ? '0 : acc_r;
    cont_cp  = {acc0, text_byte[5:0]};
    ev.start    = string_start;
    ev.stop     = 1'b0;
    ev.cp_valid = 1'b0;
    ev.cp       = cont_cp;
    pend_nxt = pend0;
    acc_nxt  = acc0;
    if (text_byte == 8'd0) begin
      ev.stop  = 1'b1;
      pend_nxt = 2'd0;
      acc_nxt  = '0;
    end else if (pend0 != 2'd0) begin
      pend_nxt = pend0 - 2'd1;
      acc_nxt  = cont_cp[ACC_W-1:0];
      if (pend0 == 2'd1) begin
        ev.cp_valid = 1'b1;
        acc_nxt     = '0;
      end
    end else if (!text_byte[7]) begin
      ev.cp_valid = 1'b1;
      ev.cp       = {{(CP_W-8){1'b0}}, text_byte};
    end else if ((text_byte & LEAD2_MASK) == LEAD2_CODE) begin
      acc_nxt  = {{(ACC_W-5){1'b0}}, text_byte[4:0]};
      pend_nxt = 2'd1;
    end else if ((text_byte & LEAD3_MASK) == LEAD3_CODE) begin
      acc_nxt  = {{(ACC_W-4){1'b0}}, text_byte[3:0]};
      pend_nxt = 2'd2;
    end else if ((text_byte & LEAD4_MASK) == LEAD4_CODE) begin
      acc_nxt  = {{(ACC_W-3){1'b0}}, text_byte[2:0]};
      pend_nxt = 2'd3;
    end else begin
      ev.cp_valid = 1'b1;
      ev.cp       = INVALID_CP;
    end
  end

  assign push_event = ev;
  assign push       = accept && (ev.start || ev.stop || ev.cp_valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
      acc_r  <= '0;
    end else if (accept) begin
      pend_r <= pend_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/utl_queue.sv -----
// Two-entry event queue between decoder and layout engine.
// Depends on utl_pkg for the event type.
`timescale 1ns / 1ps
`default_nettype none

module utl_queue
  import utl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire utl_event_t push_event,
  output logic            full,
  input  wire logic       pop,
  output logic            head_valid,
  output utl_event_t      head_event
);

  utl_event_t entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_event = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_event;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/utl_layout.sv -----
// Back end: cursor, line wrap and column logic with the result register.
// Consumes queued events and places glyphs. Depends on utl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utl_layout
  import utl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire utl_cfg_t          cfg,
  input  wire logic              head_valid,
  input  wire utl_event_t        head_event,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [CP_W-1:0]        out_code_point,
  output logic signed [PEN_W-1:0] out_pen_x,
  output logic signed [PEN_W-1:0] out_pen_y,
  output logic                   out_wide_glyph
);

  coord_t cursor_x_r, cursor_x_nxt, cursor_y_r, cursor_y_nxt;
  coord_t column_left_r, column_left_nxt;
  logic   halted_r, halted_nxt;

  logic                   out_valid_r;
  logic [CP_W-1:0]        cp_r;
  logic signed [PEN_W-1:0] pen_x_r, pen_y_r;
  logic                   wide_r;

  calc_t  ox, oy, bw, bh, iw, fs, pitch, adv, ylim;
  calc_t  cx0, cy0, cl0, pen_x, pen_y;
  coord_t sat_ox, sat_oy, y_step, ncl;
  logic   halt0, is_nl, wide, brk, ovf, col_halt, emit, back_ready;

  always_comb begin
    ox    = calc_t'($signed(cfg.origin_x));
    oy    = calc_t'($signed(cfg.origin_y));
    bw    = $signed(CALC_W'(cfg.box_width));
    bh    = $signed(CALC_W'(cfg.box_height));
    iw    = $signed(CALC_W'(cfg.image_width));
    fs    = $signed(CALC_W'(cfg.font_size));
    pitch = $signed(CALC_W'(cfg.line_pitch));
    ylim  = oy + bh - fs;
    sat_ox = sat_coord(ox);
    sat_oy = sat_coord(oy);

    if (head_event.start) begin
      cx0   = calc_t'(sat_ox);
      cl0   = calc_t'(sat_ox);
      cy0   = calc_t'(sat_oy);
      halt0 = 1'b0;
    end else begin
      cx0   = calc_t'(cursor_x_r);
      cl0   = calc_t'(column_left_r);
      cy0   = calc_t'(cursor_y_r);
      halt0 = halted_r;
    end

    is_nl    = (head_event.cp == NEWLINE_CP);
    wide     = |head_event.cp[CP_W-1:8];
    adv      = wide ? pitch : (pitch >>> 1);
    brk      = cfg.wrap_enable && (is_nl || (cx0 + fs > cl0 + bw));
    y_step   = sat_coord(cy0 + pitch);
    ovf      = calc_t'(y_step) > ylim;
    ncl      = sat_coord(cl0 + bw);
    col_halt = calc_t'(ncl) >= iw;

    cursor_x_nxt    = cx0[COORD_BITS-1:0];
    cursor_y_nxt    = cy0[COORD_BITS-1:0];
    column_left_nxt = cl0[COORD_BITS-1:0];
    halted_nxt      = halt0;
    emit            = 1'b0;
    pen_x           = cx0;
    pen_y           = cy0;

    if (head_event.stop) begin
      halted_nxt = 1'b1;
    end else if (head_event.cp_valid && !halt0) begin
      if (brk) begin
        cursor_y_nxt = y_step;
        if (ovf) begin
          column_left_nxt = ncl;
          cursor_y_nxt    = sat_oy;
        end
        if (ovf && col_halt) begin
          halted_nxt = 1'b1;
        end else begin
          cursor_x_nxt = column_left_nxt;
          pen_x        = calc_t'(column_left_nxt);
          pen_y        = calc_t'(cursor_y_nxt);
          if (!is_nl) begin
            emit         = 1'b1;
            cursor_x_nxt = sat_coord(pen_x + adv);
          end
        end
      end else if (!cfg.wrap_enable && is_nl) begin
        cursor_y_nxt = y_step;
        cursor_x_nxt = cl0[COORD_BITS-1:0];
      end else begin
        emit         = 1'b1;
        cursor_x_nxt = sat_coord(cx0 + adv);
      end
    end
  end

  assign back_ready = !out_valid_r || !out_stall;
  assign pop        = head_valid && back_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r    <= '0;
      cursor_y_r    <= '0;
      column_left_r <= '0;
      halted_r      <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      if (pop) begin
        cursor_x_r    <= cursor_x_nxt;
        cursor_y_r    <= cursor_y_nxt;
        column_left_r <= column_left_nxt;
        halted_r      <= halted_nxt;
      end
      if (pop && emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      cp_r    <= head_event.cp;
      pen_x_r <= pen_x[PEN_W-1:0];
      pen_y_r <= pen_y[PEN_W-1:0];
      wide_r  <= wide;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = cp_r;
  assign out_pen_x      = pen_x_r;
  assign out_pen_y      = pen_y_r;
  assign out_wide_glyph = wide_r;

endmodule

`default_nettype wire

// ----- sv/utf8_text_cursor_layout_unit.sv -----
// Top level of the UTF-8 text cursor layout unit: config registers, decoder,
// event queue and layout engine. Depends on utl_pkg and the utl_* modules.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_stall    in_text_byte, in_string_start
//   out_     output     out_valid / out_stall  out_code_point, out_pen_x,
//                                              out_pen_y, out_wide_glyph
//   cfg_     input      cfg_wr_en              cfg_index, cfg_wdata
//
// One byte per cycle sustained while out_stall is low; a placement is held in
// the queue entry, then in the result register, after its last byte is accepted.
// The layout engine's cursor update sets the rate.
// Reset is synchronous; no clearing pass. in_stall rises only when the
// two-entry queue is full, so a stalled output holds the input after two items.
`timescale 1ns / 1ps
`default_nettype none

module utf8_text_cursor_layout_unit
  import utl_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [7:0]             in_text_byte,
  input  wire logic                   in_string_start,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [CP_W-1:0]             out_code_point,
  output logic signed [PEN_W-1:0]     out_pen_x,
  output logic signed [PEN_W-1:0]     out_pen_y,
  output logic                        out_wide_glyph,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  utl_cfg_t   cfg_r;
  utl_event_t push_event, head_event;
  logic       accept, push, full, pop, head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x    <= '0;
      cfg_r.origin_y    <= '0;
      cfg_r.box_width   <= '0;
      cfg_r.box_height  <= '0;
      cfg_r.image_width <= '0;
      cfg_r.font_size   <= 12'd12;
      cfg_r.line_pitch  <= 13'd12;
      cfg_r.wrap_enable <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ORIGIN_X:    cfg_r.origin_x    <= cfg_wdata;
        REG_ORIGIN_Y:    cfg_r.origin_y    <= cfg_wdata;
        REG_BOX_WIDTH:   cfg_r.box_width   <= cfg_wdata[14:0];
        REG_BOX_HEIGHT:  cfg_r.box_height  <= cfg_wdata[14:0];
        REG_IMAGE_WIDTH: cfg_r.image_width <= cfg_wdata[14:0];
        REG_FONT_SIZE:   cfg_r.font_size   <= cfg_wdata[11:0];
        REG_LINE_PITCH:  cfg_r.line_pitch  <= cfg_wdata[12:0];
        REG_WRAP_ENABLE: cfg_r.wrap_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_stall = full;
  assign accept   = in_valid && !full;

  utl_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .text_byte    (in_text_byte),
    .string_start (in_string_start),
    .push_event   (push_event),
    .push         (push)
  );

  utl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_event (push_event),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_event (head_event)
  );

  utl_layout u_layout (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .head_valid     (head_valid),
    .head_event     (head_event),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point),
    .out_pen_x      (out_pen_x),
    .out_pen_y      (out_pen_y),
    .out_wide_glyph (out_wide_glyph)
  );

endmodule

`default_nettype wire

// ----- tb/placement_board_pkg.sv -----
// Scoreboard for the UTF-8 text cursor layout unit: mirrors the decoder and
// cursor state, queues the placements each accepted byte should produce and
// checks results against them. Depends on utl_pkg.
`timescale 1ns / 1ps

package placement_board_pkg;
  import utl_pkg::*;

  typedef struct packed {
    logic [CP_W-1:0]         code_point;
    logic signed [PEN_W-1:0] pen_x;
    logic signed [PEN_W-1:0] pen_y;
    logic                    wide_glyph;
  } placement_t;

  class placement_board;
    logic [15:0]     origin_x, origin_y;
    logic [14:0]     box_width, box_height, image_width;
    logic [11:0]     font_size;
    logic [12:0]     line_pitch;
    logic            wrap_enable;
    logic [1:0]      seq_left;
    logic [CP_W-1:0] code_acc;
    longint          pen_x, pen_y, col_left;
    bit              stopped;
    placement_t      expected[$];
    int              placed, errors;

    function new();
      origin_x = '0;
      origin_y = '0;
      box_width = '0;
      box_height = '0;
      image_width = '0;
      font_size = 12'd12;
      line_pitch = 13'd12;
      wrap_enable = 1'b1;
      seq_left = '0;
      code_acc = '0;
      pen_x = 0;
      pen_y = 0;
      col_left = 0;
      stopped = 1'b1;
      placed = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_ORIGIN_X:    origin_x = v;
        REG_ORIGIN_Y:    origin_y = v;
        REG_BOX_WIDTH:   box_width = v[14:0];
        REG_BOX_HEIGHT:  box_height = v[14:0];
        REG_IMAGE_WIDTH: image_width = v[14:0];
        REG_FONT_SIZE:   font_size = v[11:0];
        REG_LINE_PITCH:  line_pitch = v[12:0];
        REG_WRAP_ENABLE: wrap_enable = v[0];
        default: ;
      endcase
    endfunction

    function longint clamp_coord(longint v);
      longint hi;
      hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    // Returns 0 when the byte is ignored because the cursor is halted.
    function bit note_byte(logic [7:0] b, logic s);
      logic [CP_W-1:0] cp;
      longint fs, pitch, ox, oy, bw, bh, iw;
      bit nl;
      placement_t p;
      fs = longint'(font_size);
      pitch = longint'(line_pitch);
      bw = longint'(box_width);
      bh = longint'(box_height);
      iw = longint'(image_width);
      ox = longint'($signed(origin_x));
      oy = longint'($signed(origin_y));
      if (s) begin
        pen_x = clamp_coord(ox);
        col_left = clamp_coord(ox);
        pen_y = clamp_coord(oy);
        stopped = 1'b0;
        seq_left = '0;
        code_acc = '0;
      end
      if (stopped) return 1'b0;
      if (b == 8'h00) begin
        seq_left = '0;
        code_acc = '0;
        stopped = 1'b1;
        return 1'b1;
      end
      if (seq_left != 0) begin
        code_acc = {code_acc[CP_W-7:0], b[5:0]};
        seq_left--;
        if (seq_left != 0) return 1'b1;
        cp = code_acc;
      end else if (!b[7]) begin
        cp = CP_W'(b);
      end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
        code_acc = CP_W'(b[4:0]);
        seq_left = 2'd1;
        return 1'b1;
      end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
        code_acc = CP_W'(b[3:0]);
        seq_left = 2'd2;
        return 1'b1;
      end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
        code_acc = CP_W'(b[2:0]);
        seq_left = 2'd3;
        return 1'b1;
      end else begin
        cp = INVALID_CP;
      end
      code_acc = '0;
      nl = (cp == NEWLINE_CP);

      if (wrap_enable) begin
        if (nl || pen_x + fs > col_left + bw) begin
          pen_y = clamp_coord(pen_y + pitch);
          if (pen_y + fs > oy + bh) begin
            col_left = clamp_coord(col_left + bw);
            pen_y = clamp_coord(oy);
            if (col_left >= iw) begin
              stopped = 1'b1;
              seq_left = '0;
              return 1'b1;
            end
          end
          pen_x = col_left;
          if (nl) return 1'b1;
        end
      end else if (nl) begin
        pen_y = clamp_coord(pen_y + pitch);
        pen_x = col_left;
        return 1'b1;
      end

      p.code_point = cp;
      p.pen_x = pen_x[PEN_W-1:0];
      p.pen_y = pen_y[PEN_W-1:0];
      p.wide_glyph = (cp >= 21'd256);
      expected.push_back(p);
      placed++;
      pen_x = clamp_coord(pen_x + ((cp < 21'd256) ? pitch / 2 : pitch));
      return 1'b1;
    endfunction

    function void check_placement(logic [CP_W-1:0] cp, logic [PEN_W-1:0] x,
                                  logic [PEN_W-1:0] y, logic wide);
      placement_t p;
      if (expected.size() == 0) begin
        $error("unexpected placement: code_point %0h pen_x %0d pen_y %0d",
               cp, $signed(x), $signed(y));
        errors++;
        return;
      end
      p = expected.pop_front();
      if (p.code_point !== cp) begin
        $error("code_point: expected %0h, actual %0h", p.code_point, cp);
        errors++;
      end
      if (p.pen_x !== x) begin
        $error("pen_x: expected %0d, actual %0d", $signed(p.pen_x), $signed(x));
        errors++;
      end
      if (p.pen_y !== y) begin
        $error("pen_y: expected %0d, actual %0d", $signed(p.pen_y), $signed(y));
        errors++;
      end
      if (p.wide_glyph !== wide) begin
        $error("wide_glyph: expected %0b, actual %0b", p.wide_glyph, wide);
        errors++;
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

endpackage

// ----- tb/testbench.sv -----
// Testbench for utf8_text_cursor_layout_unit: directed and random UTF-8 strings
// under several layout settings, with random gaps and stalls on both channels.
// Depends on utl_pkg and placement_board_pkg.
`timescale 1ns / 1ps

module testbench;
  import utl_pkg::*;
  import placement_board_pkg::*;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [7:0]              in_text_byte;
  logic                    in_string_start;
  logic                    out_valid;
  logic                    out_stall;
  logic [CP_W-1:0]         out_code_point;
  logic signed [PEN_W-1:0] out_pen_x;
  logic signed [PEN_W-1:0] out_pen_y;
  logic                    out_wide_glyph;
  logic                    cfg_wr_en;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_wdata;

  placement_board board;
  int  live_items;
  bit  tx_quiet;
  bit  fresh;

  utf8_text_cursor_layout_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_text_byte    (in_text_byte),
    .in_string_start (in_string_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_point  (out_code_point),
    .out_pen_x       (out_pen_x),
    .out_pen_y       (out_pen_y),
    .out_wide_glyph  (out_wide_glyph),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic send_byte(input logic [7:0] b, input logic s);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_text_byte <= b;
    in_string_start <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (board.note_byte(b, s)) live_items++;
  endtask

  task automatic put(input logic [7:0] b);
    send_byte(b, fresh);
    fresh = 1'b0;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    board.set_reg(idx, v);
  endtask

  task automatic configure(input logic [15:0] ox, oy, bw, bh, iw, fs, lp, wr);
    drain_results();
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_BOX_WIDTH, bw);
    write_reg(REG_BOX_HEIGHT, bh);
    write_reg(REG_IMAGE_WIDTH, iw);
    write_reg(REG_FONT_SIZE, fs);
    write_reg(REG_LINE_PITCH, lp);
    write_reg(REG_WRAP_ENABLE, wr);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_glyph();
    int r;
    logic [CP_W-1:0] cp;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      put(8'($urandom_range(8'h20, 8'h7e)));
    end else if (r < 48) begin
      put(8'h0a);
    end else if (r < 60) begin
      cp = CP_W'($urandom_range(0, 21'h7ff));
      put({3'b110, cp[10:6]});
      put({2'b10, cp[5:0]});
    end else if (r < 70) begin
      cp = CP_W'($urandom_range(0, 21'hffff));
      put({4'b1110, cp[15:12]});
      put({2'b10, cp[11:6]});
      put({2'b10, cp[5:0]});
    end else if (r < 78) begin
      cp = CP_W'($urandom_range(0, 21'h1fffff));
      put({5'b11110, cp[20:18]});
      put({2'b10, cp[17:12]});
      put({2'b10, cp[11:6]});
      put({2'b10, cp[5:0]});
    end else if (r < 84) begin
      put(8'($urandom_range(1, 255)));
    end else if (r < 88) begin
      if ($urandom_range(0, 1) == 0) begin
        put(8'hc0);
      end else begin
        put(8'he0);
        put(8'h80);
      end
      put(8'h8a);
    end else if (r < 92) begin
      put({4'b1110, 4'($urandom_range(0, 15))});
    end else if (r < 96) begin
      fresh = 1'b1;
      put(8'($urandom_range(8'h20, 8'h7e)));
    end else begin
      put(8'h00);
      fresh = 1'b1;
    end
  endtask

  task automatic stream_text(input int target);
    int live0, placed0, n;
    live0 = live_items;
    placed0 = board.placed;
    while ((live_items - live0 < target) ||
           (board.placed - placed0 < 40 && live_items - live0 < 3 * target)) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 12);
        repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end else begin
        n = $urandom_range(1, 40);
        fresh = 1'b1;
        repeat (n) send_glyph();
        if ($urandom_range(0, 9) < 7) put(8'h00);
      end
    end
  endtask

  task automatic run_phase(input logic [15:0] ox, oy, bw, bh, iw, fs, lp, wr,
                           input int target);
    configure(ox, oy, bw, bh, iw, fs, lp, wr);
    stream_text(target / 2);
    drain_results();
    stream_text(target - target / 2);
  endtask

  initial begin : result_sink
    int hold;
    int taken;
    bit quiet;
    hold = 0;
    taken = 0;
    quiet = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && !out_stall) begin
        board.check_placement(out_code_point, out_pen_x, out_pen_y, out_wide_glyph);
        taken++;
        if (taken % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
        hold = quiet ? 0 : $urandom_range(0, 4);
      end
      @(negedge clk);
      if (hold != 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int fs, lp, bw, bh, i;
    board = new();
    live_items = 0;
    tx_quiet = 1'b0;
    fresh = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_text_byte = 8'h00;
    in_string_start = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_ORIGIN_X;
    cfg_wdata = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // ignored: halted out of reset
    send_byte(8'h5a, 1'b0);
    configure(16'd10, 16'd20, 16'd200, 16'd100, 16'd1000, 16'd12, 16'd14, 16'd1);
    send_byte(8'h41, 1'b1);
    send_byte(8'h7f, 1'b0);
    send_byte(8'hc3, 1'b0);
    send_byte(8'ha9, 1'b0);
    send_byte(8'he2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hac, 1'b0);
    send_byte(8'hf7, 1'b0);
    send_byte(8'hbf, 1'b0);
    send_byte(8'hbf, 1'b0);
    send_byte(8'hbf, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hf8, 1'b0);
    send_byte(8'h0a, 1'b0);
    send_byte(8'hc0, 1'b0);
    send_byte(8'h8a, 1'b0);
    send_byte(8'hc3, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'he2, 1'b0);
    send_byte(8'h42, 1'b1);
    send_byte(8'he2, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h43, 1'b0);
    send_byte(8'h44, 1'b1);
    send_byte(8'h00, 1'b0);

    run_phase(16'd10, 16'd20, 16'd120, 16'd60, 16'd400, 16'd12, 16'd14, 16'd1, 130);
    run_phase(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'd2048, 16'd8191,
              16'd0, 130);
    run_phase(16'h8000, 16'h8000, 16'd0, 16'd0, 16'd0, 16'd12, 16'd1, 16'd1, 120);
    run_phase(16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
              16'hffff, 130);
    run_phase(16'h8000, 16'h0000, 16'd40, 16'd30, 16'd0, 16'd0, 16'd0, 16'd0, 110);
    for (i = 0; i < 2; i++) begin
      fs = $urandom_range(0, 40);
      lp = $urandom_range(0, 60);
      bw = $urandom_range(2 * fs + 10, 400);
      bh = $urandom_range(2 * (fs + lp) + 10, 300);
      run_phase(16'($urandom_range(0, 16'hffff)), 16'($urandom_range(0, 16'hffff)),
                16'(bw), 16'(bh), 16'($urandom_range(0, 2000)), 16'(fs), 16'(lp),
                16'($urandom_range(0, 1)), 130);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    for (i = 0; i < 2000 && board.pending() != 0; i++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.pending() != 0) begin
      $error("%0d placements never arrived", board.pending());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
